// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_IMPLY checks a same-cycle implication; ASSERT_NEXT checks the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/b64e_pkg.sv
package b64e_pkg;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAD     = 8'h3D;

	localparam int unsigned SYMS_PER_GROUP = 4;

	// One encoded group: sym[0] leaves first.
	typedef struct packed {
		logic [SYMS_PER_GROUP-1:0][7:0] sym;
		logic                           last;
	} group_t;

	// Map a 6-bit value through the alphabet A-Z, a-z, '+', '/', 0-9.
	function automatic logic [7:0] alphabet(input logic [5:0] idx);
		logic [7:0] wide;
		wide = {2'b00, idx};
		if (idx < 6'd26)
			alphabet = CH_UPPER_A + wide;
		else if (idx < 6'd52)
			alphabet = CH_LOWER_A + (wide - 8'd26);
		else if (idx == 6'd52)
			alphabet = CH_PLUS;
		else if (idx == 6'd53)
			alphabet = CH_SLASH;
		else
			alphabet = CH_DIGIT_0 + (wide - 8'd54);
	endfunction

endpackage

// File: rtl/core/b64e_if.sv
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_sym_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol_char;
	logic       last_symbol;

	modport source (output valid, output symbol_char, output last_symbol, input ready);
	modport sink (input valid, input symbol_char, input last_symbol, output ready);
endinterface

// File: rtl/core/b64e_sym_buf.sv
module b64e_sym_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  b64e_pkg::group_t grp,
	output logic             free,
	output logic [2:0]       level,
	b64e_sym_if.source       out_sym
);

	logic [b64e_pkg::SYMS_PER_GROUP-1:0][7:0] sym_q;
	logic                                     end_q;
	logic [2:0]                               cnt_q;
	logic                                     pop;

	assign pop   = out_sym.valid && out_sym.ready;
	assign free  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_sym.ready);
	assign level = cnt_q;

	assign out_sym.valid       = (cnt_q != 3'd0);
	assign out_sym.symbol_char = sym_q[0];
	assign out_sym.last_symbol = end_q && (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= 3'(b64e_pkg::SYMS_PER_GROUP);
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// Payload: load a whole group, or advance one symbol per pop.
	always_ff @(posedge clk) begin
		if (load) begin
			sym_q <= grp.sym;
			end_q <= grp.last;
		end else if (pop) begin
			sym_q <= {8'h00, sym_q[b64e_pkg::SYMS_PER_GROUP-1:1]};
		end
	end

endmodule

// File: rtl/core/base64_stream_encoder_top.sv
// Base64-style stream encoder with its own alphabet order. Bytes arrive on
// in_byte, one word per handshake, with end_of_message marking the last byte of
// a message; symbols leave on out_sym as ASCII, one word per handshake, with
// last_symbol on the final symbol of the message. Up to two bytes are held; the
// third byte of a group, or any byte flagged end_of_message, loads four symbols
// into a four-entry symbol buffer, padded with '=' when the group is short. The
// alphabet is A-Z, a-z, '+', '/', 0-9. The first symbol is offered the cycle
// after the byte that completes the group. A byte is accepted whenever the
// symbol buffer is empty or hands out its last symbol in that cycle, so bytes
// wait while the buffer drains at one symbol per cycle while out_sym is ready.
// Every message ends in four symbols; there is no empty message.
`include "assert_macros.svh"

module base64_stream_encoder_top (
	input logic        clk,
	input logic        arst_n,
	b64e_byte_if.sink  in_byte,
	b64e_sym_if.source out_sym
);

	// Pending bytes, older byte in the upper half.
	logic [15:0] pend_bytes_q;
	logic [1:0]  pend_cnt_q;

	logic [1:0]       held;
	logic [1:0]       total;
	logic             grp_done;
	logic             in_fire;
	logic             load;
	logic             buf_free;
	logic [2:0]       buf_level;
	logic [23:0]      bits;
	b64e_pkg::group_t grp;

	// A count of three never arises; treat it as two.
	assign held     = (pend_cnt_q == 2'd3) ? 2'd2 : pend_cnt_q;
	assign total    = held + 2'd1;
	assign grp_done = (total == 2'd3) || in_byte.end_of_message;

	// Hold off every byte while the buffer holds symbols, unless its last one leaves now.
	assign in_byte.ready = buf_free;
	assign in_fire       = in_byte.valid && in_byte.ready;
	assign load          = in_fire && grp_done;

	// Assemble the 24-bit group, left-aligned and zero-padded.
	always_comb begin
		case (total)
			2'd3:    bits = {pend_bytes_q, in_byte.data_byte};
			2'd2:    bits = {pend_bytes_q[7:0], in_byte.data_byte, 8'h00};
			default: bits = {in_byte.data_byte, 16'h0000};
		endcase
	end

	// Map sextets, most significant first; pad the tail with '=' for short groups.
	always_comb begin
		grp.sym[0] = b64e_pkg::alphabet(bits[23:18]);
		grp.sym[1] = b64e_pkg::alphabet(bits[17:12]);
		grp.sym[2] = (total >= 2'd2) ? b64e_pkg::alphabet(bits[11:6]) : b64e_pkg::CH_PAD;
		grp.sym[3] = (total == 2'd3) ? b64e_pkg::alphabet(bits[5:0]) : b64e_pkg::CH_PAD;
		grp.last   = in_byte.end_of_message;
	end

	// Hold a byte that does not finish a group; drop the state once a group goes out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bytes_q <= 16'h0000;
			pend_cnt_q   <= 2'd0;
		end else if (in_fire) begin
			if (grp_done) begin
				pend_bytes_q <= 16'h0000;
				pend_cnt_q   <= 2'd0;
			end else begin
				pend_bytes_q <= {pend_bytes_q[7:0], in_byte.data_byte};
				pend_cnt_q   <= total;
			end
		end
	end

	b64e_sym_buf u_sym_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.grp     (grp),
		.free    (buf_free),
		.level   (buf_level),
		.out_sym (out_sym)
	);

	// A completed group always fills the whole buffer.
	`ASSERT_NEXT(a_load_fills, clk, arst_n, load, buf_level == 3'd4)
	// The end mark only shows on the final buffered symbol.
	`ASSERT_IMPLY(a_last_at_tail, clk, arst_n, out_sym.valid && out_sym.last_symbol, buf_level == 3'd1)
	// Never more than two bytes held.
	`ASSERT_IMPLY(a_pend_range, clk, arst_n, 1'b1, pend_cnt_q != 2'd3)

endmodule
